// ===== rtl/core/pdslew_pkg.sv =====
package pdslew_pkg;

  // Encoder position width.
  localparam int POS_WIDTH = 24;

  // Register field widths.
  localparam int TGT_W   = 21;
  localparam int MAXS_W  = 9;
  localparam int SLANT_W = 9;
  localparam int GAIN_W  = 12;
  localparam int STEP_W  = 10;
  localparam int CFG_W   = 21;
  localparam int IDX_W   = 3;

  // Motor command width.
  localparam int DRV_W = 11;

  // Turn set point: |target| * coef >> shift, then divide by five through a reciprocal.
  localparam int SET_W       = TGT_W + 2;
  localparam int COEF_W      = 6;
  localparam int RECIP_W     = 24;
  localparam int RECIP_SHIFT = 26;
  localparam logic [RECIP_W-1:0] RECIP_FIVE = 24'd13421773;
  localparam logic [COEF_W-1:0]  COEF_POS   = 6'd47;  // 2.35 = 47 / 20
  localparam logic [COEF_W-1:0]  COEF_NEG   = 6'd23;  // 2.3  = 23 / 10

  // Error and shared multiplier widths.
  localparam int ERR_W     = ((POS_WIDTH > SET_W) ? POS_WIDTH : SET_W) + 2;
  localparam int MUL_A_W   = (ERR_W + 1 > RECIP_W + 1) ? ERR_W + 1 : RECIP_W + 1;
  localparam int MUL_B_W   = RECIP_W + 1;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int FRAC_BITS = 8;

  // Fixed Q4.8 turn gains.
  localparam logic [GAIN_W-1:0] TURN_KP = 12'd230;
  localparam logic [GAIN_W-1:0] TURN_KD = 12'd896;

  // Stall detector.
  localparam int CNT_W = 3;
  localparam logic [CNT_W-1:0] STALL_LIMIT = 3'd4;
  localparam logic [CNT_W-1:0] STILL_MAX   = 3'd5;
  localparam int STALL_THRESH = 3;

  typedef logic signed [POS_WIDTH-1:0] pos_t;
  typedef logic signed [DRV_W-1:0]     drive_t;

  typedef enum logic [IDX_W-1:0] {
    REG_MODE       = 3'd0,
    REG_TARGET     = 3'd1,
    REG_MAX_SPEED  = 3'd2,
    REG_SLANT      = 3'd3,
    REG_GAIN_P     = 3'd4,
    REG_GAIN_D     = 3'd5,
    REG_ACCEL_SIZE = 3'd6,
    REG_DECEL_SIZE = 3'd7
  } reg_idx_e;

  // Move cur toward cmd by at most one step; accel step when magnitude grows.
  function automatic drive_t slew_step(drive_t cur, drive_t cmd,
                                       logic [STEP_W-1:0] accel,
                                       logic [STEP_W-1:0] decel);
    logic [DRV_W-1:0]        mag_cur;
    logic [DRV_W-1:0]        mag_cmd;
    logic [STEP_W-1:0]       step;
    logic signed [DRV_W+1:0] step_x;
    logic signed [DRV_W+1:0] cur_x;
    logic signed [DRV_W+1:0] cmd_x;
    logic signed [DRV_W+1:0] hi;
    logic signed [DRV_W+1:0] lo;
    drive_t                  res;
    mag_cur = cur[DRV_W-1] ? DRV_W'(-cur) : DRV_W'(cur);
    mag_cmd = cmd[DRV_W-1] ? DRV_W'(-cmd) : DRV_W'(cmd);
    step    = (mag_cur < mag_cmd) ? accel : decel;
    step_x  = $signed({{(DRV_W + 2 - STEP_W){1'b0}}, step});
    cur_x   = (DRV_W + 2)'(cur);
    cmd_x   = (DRV_W + 2)'(cmd);
    hi      = cur_x + step_x;
    lo      = cur_x - step_x;
    if (cmd_x > hi) begin
      res = hi[DRV_W-1:0];
    end else if (cmd_x < lo) begin
      res = lo[DRV_W-1:0];
    end else begin
      res = cmd;
    end
    return res;
  endfunction

endpackage

// ===== rtl/core/pd_drive_controller_with_slew.sv =====
// PD drive controller with slew-limited left/right motor commands.
//
// Input channel (in_valid_i/in_ready_o): one word per control tick, carrying
// the left and right encoder positions. Output channel (out_valid_o/
// out_ready_i): one word per tick with the left and right drive commands and
// the still-moving flag. Configuration is a plain write port (cfg_we_i,
// cfg_idx_i, cfg_wdata_i) taken on any edge with cfg_we_i high; write it only
// while the block is idle.
//
// Datapath: one shared signed multiplier under a small sequencer does all the
// products. A drive-mode tick passes the proportional product, derivative
// multiply-accumulate and finish states before its output word is raised; a
// turn-mode tick first passes three more states that build the set point
// (coefficient product, reciprocal-of-five product, sign). The input is ready
// only in the idle state, so a new tick is taken only once the last is done.
//
// Reset (rst_ni low, asynchronous) loads the register defaults and zeroes the
// speeds, previous errors, stall state and output valid. A stalled receiver
// holds the finished word on the outputs; the next word is still accepted,
// then waits in the finish state, input not ready, until the held word goes.
module pd_drive_controller_with_slew (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  pdslew_pkg::pos_t                   left_position_i,
  input  pdslew_pkg::pos_t                   right_position_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output pdslew_pkg::drive_t                 left_drive_o,
  output pdslew_pkg::drive_t                 right_drive_o,
  output logic                               still_moving_o,
  input  logic                               cfg_we_i,
  input  logic [pdslew_pkg::IDX_W-1:0]       cfg_idx_i,
  input  logic [pdslew_pkg::CFG_W-1:0]       cfg_wdata_i
);
  import pdslew_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SET1,
    S_SET2,
    S_SET3,
    S_MULP,
    S_MULD,
    S_FIN
  } state_e;

  // Configuration registers.
  logic                     mode_q;
  logic signed [TGT_W-1:0]  target_q;
  logic [MAXS_W-1:0]        max_speed_q;
  logic signed [SLANT_W-1:0] slant_q;
  logic [GAIN_W-1:0]        gain_p_q;
  logic [GAIN_W-1:0]        gain_d_q;
  logic [STEP_W-1:0]        accel_q;
  logic [STEP_W-1:0]        decel_q;

  // Sequencer and datapath state.
  state_e                    state_q;
  pos_t                      lp_q;
  pos_t                      rp_q;
  logic signed [SET_W-1:0]   set_q;
  logic signed [ERR_W-1:0]   err_q;
  logic signed [PROD_W-1:0]  prod_q;
  drive_t                    left_speed_q;
  drive_t                    right_speed_q;
  logic signed [ERR_W-1:0]   prev_drive_q;
  logic signed [ERR_W-1:0]   prev_turn_q;
  logic [POS_WIDTH-1:0]      last_level_q;
  logic [CNT_W-1:0]          still_cnt_q;
  logic signed [TGT_W-1:0]   last_target_q;
  logic                      out_valid_q;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= 1'b1;
      target_q    <= '0;
      max_speed_q <= MAXS_W'(200);
      slant_q     <= '0;
      gain_p_q    <= GAIN_W'(77);
      gain_d_q    <= GAIN_W'(128);
      accel_q     <= STEP_W'(9);
      decel_q     <= STEP_W'(256);
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_MODE:       mode_q      <= cfg_wdata_i[0];
        REG_TARGET:     target_q    <= cfg_wdata_i[TGT_W-1:0];
        REG_MAX_SPEED:  max_speed_q <= cfg_wdata_i[MAXS_W-1:0];
        REG_SLANT:      slant_q     <= cfg_wdata_i[SLANT_W-1:0];
        REG_GAIN_P:     gain_p_q    <= cfg_wdata_i[GAIN_W-1:0];
        REG_GAIN_D:     gain_d_q    <= cfg_wdata_i[GAIN_W-1:0];
        REG_ACCEL_SIZE: accel_q     <= cfg_wdata_i[STEP_W-1:0];
        REG_DECEL_SIZE: decel_q     <= cfg_wdata_i[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Turn set point: positive target scales by 47/20, otherwise by 23/10.
  logic                    tgt_pos;
  logic [TGT_W-1:0]        tgt_mag;
  logic [RECIP_W-1:0]      quo_in;
  logic [SET_W-1:0]        quo;
  logic signed [SET_W-1:0] set_d;

  assign tgt_pos = !target_q[TGT_W-1] && (target_q != '0);
  assign tgt_mag = target_q[TGT_W-1] ? TGT_W'(-target_q) : TGT_W'(target_q);
  assign quo_in  = tgt_pos ? prod_q[RECIP_W+1:2] : prod_q[RECIP_W:1];
  assign quo     = prod_q[RECIP_SHIFT+SET_W-1:RECIP_SHIFT];
  assign set_d   = tgt_pos ? $signed(quo) : -$signed(quo);

  // Turn measurement: (right - left) / 2 truncated toward zero.
  logic signed [POS_WIDTH:0] pos_dif;
  logic signed [POS_WIDTH:0] pos_half;

  assign pos_dif  = (POS_WIDTH + 1)'(rp_q) - (POS_WIDTH + 1)'(lp_q);
  assign pos_half = (pos_dif + $signed({{POS_WIDTH{1'b0}}, pos_dif[POS_WIDTH]})) >>> 1;

  // Error, derivative term and gain selection for the active mode.
  logic signed [ERR_W-1:0]   err_now;
  logic signed [ERR_W-1:0]   prev_sel;
  logic signed [MUL_A_W-1:0] derr;
  logic [GAIN_W-1:0]         kp_sel;
  logic [GAIN_W-1:0]         kd_sel;

  assign err_now  = mode_q ? (ERR_W'(target_q) - ERR_W'(lp_q))
                           : (ERR_W'(set_q) - ERR_W'(pos_half));
  assign prev_sel = mode_q ? prev_drive_q : prev_turn_q;
  assign derr     = MUL_A_W'(err_q) - MUL_A_W'(prev_sel);
  assign kp_sel   = mode_q ? gain_p_q : TURN_KP;
  assign kd_sel   = mode_q ? gain_d_q : TURN_KD;

  // Shared signed multiplier.
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  mul_p;

  always_comb begin
    case (state_q)
      S_SET1: begin
        mul_a = MUL_A_W'($signed({1'b0, tgt_mag}));
        mul_b = MUL_B_W'($signed({1'b0, (tgt_pos ? COEF_POS : COEF_NEG)}));
      end
      S_SET2: begin
        mul_a = MUL_A_W'($signed({1'b0, quo_in}));
        mul_b = MUL_B_W'($signed({1'b0, RECIP_FIVE}));
      end
      S_MULP: begin
        mul_a = MUL_A_W'(err_now);
        mul_b = MUL_B_W'($signed({1'b0, kp_sel}));
      end
      default: begin
        mul_a = derr;
        mul_b = MUL_B_W'($signed({1'b0, kd_sel}));
      end
    endcase
  end

  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

  // PD output: divide by 256 toward zero, clamp to +-max_speed.
  logic signed [PROD_W-1:0] pd_rnd;
  logic signed [PROD_W-1:0] pd_q8;
  logic signed [PROD_W-1:0] max_x;
  drive_t                   sp;
  drive_t                   slant_x;
  drive_t                   cmd_l;
  drive_t                   cmd_r;
  drive_t                   new_l;
  drive_t                   new_r;

  assign pd_rnd = prod_q + (prod_q[PROD_W-1] ? PROD_W'(255) : PROD_W'(0));
  assign pd_q8  = pd_rnd >>> FRAC_BITS;
  assign max_x  = PROD_W'($signed({1'b0, max_speed_q}));

  always_comb begin
    if (pd_q8 > max_x) begin
      sp = DRV_W'(max_x);
    end else if (pd_q8 < -max_x) begin
      sp = DRV_W'(-max_x);
    end else begin
      sp = pd_q8[DRV_W-1:0];
    end
  end

  assign slant_x = DRV_W'(slant_q);
  assign cmd_l   = mode_q ? (sp - slant_x) : -sp;
  assign cmd_r   = mode_q ? (sp + slant_x) : sp;
  assign new_l   = slew_step(left_speed_q, cmd_l, accel_q, decel_q);
  assign new_r   = slew_step(right_speed_q, cmd_r, accel_q, decel_q);

  // Stall detector: level = (|left| + |right|) / 2.
  logic [POS_WIDTH-1:0]      abs_l;
  logic [POS_WIDTH-1:0]      abs_r;
  logic [POS_WIDTH:0]        lvl_sum;
  logic [POS_WIDTH-1:0]      level;
  logic signed [POS_WIDTH:0] lvl_dif;
  logic [POS_WIDTH:0]        lvl_mag;
  logic [CNT_W-1:0]          cnt_next;

  assign abs_l   = lp_q[POS_WIDTH-1] ? POS_WIDTH'(-lp_q) : POS_WIDTH'(lp_q);
  assign abs_r   = rp_q[POS_WIDTH-1] ? POS_WIDTH'(-rp_q) : POS_WIDTH'(rp_q);
  assign lvl_sum = {1'b0, abs_l} + {1'b0, abs_r};
  assign level   = lvl_sum[POS_WIDTH:1];
  assign lvl_dif = $signed({1'b0, last_level_q}) - $signed({1'b0, level});
  assign lvl_mag = lvl_dif[POS_WIDTH] ? (POS_WIDTH + 1)'(-lvl_dif)
                                      : (POS_WIDTH + 1)'(lvl_dif);

  always_comb begin
    if (lvl_mag < (POS_WIDTH + 1)'(STALL_THRESH)) begin
      cnt_next = (still_cnt_q < STILL_MAX) ? still_cnt_q + CNT_W'(1) : still_cnt_q;
    end else begin
      cnt_next = '0;
    end
    if (target_q != last_target_q) begin
      cnt_next = '0;
    end
  end

  logic fin_go;
  logic fin_fire;
  assign fin_go   = !out_valid_q || out_ready_i;
  assign fin_fire = (state_q == S_FIN) && fin_go;

  // Sequencer, datapath registers and output word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      lp_q          <= '0;
      rp_q          <= '0;
      set_q         <= '0;
      err_q         <= '0;
      prod_q        <= '0;
      left_speed_q  <= '0;
      right_speed_q <= '0;
      prev_drive_q  <= '0;
      prev_turn_q   <= '0;
      last_level_q  <= '0;
      still_cnt_q   <= '0;
      last_target_q <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      // Raise a fresh word out of finish, else drop the taken one.
      if (fin_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            lp_q    <= left_position_i;
            rp_q    <= right_position_i;
            state_q <= mode_q ? S_MULP : S_SET1;
          end
        end
        S_SET1: begin
          prod_q  <= mul_p;
          state_q <= S_SET2;
        end
        S_SET2: begin
          prod_q  <= mul_p;
          state_q <= S_SET3;
        end
        S_SET3: begin
          set_q   <= set_d;
          state_q <= S_MULP;
        end
        S_MULP: begin
          prod_q  <= mul_p;
          err_q   <= err_now;
          state_q <= S_MULD;
        end
        S_MULD: begin
          prod_q  <= prod_q + mul_p;
          state_q <= S_FIN;
        end
        S_FIN: begin
          // Hold here until the previous word has left the output.
          if (fin_go) begin
            left_speed_q  <= new_l;
            right_speed_q <= new_r;
            if (mode_q) begin
              prev_drive_q <= err_q;
            end else begin
              prev_turn_q <= err_q;
            end
            last_level_q  <= level;
            still_cnt_q   <= cnt_next;
            last_target_q <= target_q;
            state_q       <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o     = (state_q == S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign left_drive_o   = left_speed_q;
  assign right_drive_o  = right_speed_q;
  assign still_moving_o = !(still_cnt_q > STALL_LIMIT);

`ifndef SYNTHESIS
  // A new word only appears out of the finish state.
  a_valid_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_FIN))
    else $error("output word raised outside finish state");

  // A word waiting on the receiver keeps its commands.
  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> ($stable(left_speed_q) && $stable(right_speed_q)))
    else $error("drive commands changed while output stalled");

  // Stall count saturates at five.
  a_cnt_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    still_cnt_q <= STILL_MAX)
    else $error("stall count beyond saturation");

  // Slew limiter never reaches the negative rail code.
  a_speed_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (left_speed_q != drive_t'({1'b1, {(DRV_W - 1){1'b0}}})) &&
    (right_speed_q != drive_t'({1'b1, {(DRV_W - 1){1'b0}}})))
    else $error("drive command out of range");
`endif

endmodule

// ===== tb/pd_drive_controller_with_slew_test.sv =====
module pd_drive_controller_with_slew_test;
  import pdslew_pkg::*;

  localparam int CYCLE_LIMIT     = 600000;
  localparam int PHASES          = 8;
  localparam int WORDS_PER_PHASE = 225;
  localparam int HOLD_OFF_CYCLES = 250;
  localparam pos_t POS_MAX = {1'b0, {(POS_WIDTH - 1){1'b1}}};
  localparam pos_t POS_MIN = {1'b1, {(POS_WIDTH - 1){1'b0}}};

  typedef struct {
    drive_t left;
    drive_t right;
    logic   moving;
  } drive_word_t;

  // Track the controller: registers, speeds, previous errors and stall state.
  // Compute the drive word for each accepted position pair and compare the
  // words coming out, oldest first.
  class drive_command_tracker;
    logic                      mode;
    logic signed [TGT_W-1:0]   target;
    logic [MAXS_W-1:0]         max_speed;
    logic signed [SLANT_W-1:0] slant;
    logic [GAIN_W-1:0]         gain_p;
    logic [GAIN_W-1:0]         gain_d;
    logic [STEP_W-1:0]         accel_size;
    logic [STEP_W-1:0]         decel_size;
    longint                    left_speed;
    longint                    right_speed;
    longint                    prev_drive_err;
    longint                    prev_turn_err;
    longint                    last_level;
    longint                    last_target;
    int                        still_count;
    drive_word_t               pending_words[$];
    int                        mismatches;
    int                        words_checked;
    int                        drive_ticks;
    int                        turn_ticks;
    int                        stalled_words;

    function new();
      mode           = 1'b1;
      target         = '0;
      max_speed      = 200;
      slant          = '0;
      gain_p         = 77;
      gain_d         = 128;
      accel_size     = 9;
      decel_size     = 256;
      left_speed     = 0;
      right_speed    = 0;
      prev_drive_err = 0;
      prev_turn_err  = 0;
      last_level     = 0;
      last_target    = 0;
      still_count    = 0;
      mismatches     = 0;
      words_checked  = 0;
      drive_ticks    = 0;
      turn_ticks     = 0;
      stalled_words  = 0;
    endfunction

    function void set_reg(reg_idx_e idx, logic [CFG_W-1:0] v);
      case (idx)
        REG_MODE:       mode       = v[0];
        REG_TARGET:     target     = v[TGT_W-1:0];
        REG_MAX_SPEED:  max_speed  = v[MAXS_W-1:0];
        REG_SLANT:      slant      = v[SLANT_W-1:0];
        REG_GAIN_P:     gain_p     = v[GAIN_W-1:0];
        REG_GAIN_D:     gain_d     = v[GAIN_W-1:0];
        REG_ACCEL_SIZE: accel_size = v[STEP_W-1:0];
        REG_DECEL_SIZE: decel_size = v[STEP_W-1:0];
        default: ;
      endcase
    endfunction

    function longint mag(longint v);
      return (v < 0) ? -v : v;
    endfunction

    // Take the accel step when the magnitude grows, the decel step otherwise.
    function longint slew(longint cur, longint cmd);
      longint step;
      step = (mag(cur) < mag(cmd)) ? longint'(accel_size) : longint'(decel_size);
      if (cmd > cur + step) return cur + step;
      if (cmd < cur - step) return cur - step;
      return cmd;
    endfunction

    function longint pd_speed(longint err, longint prev, longint kp, longint kd);
      longint sp;
      longint lim;
      sp  = (err * kp + (err - prev) * kd) / 256;
      lim = max_speed;
      if (sp > lim) sp = lim;
      if (sp < -lim) sp = -lim;
      return sp;
    endfunction

    function void note_positions(pos_t lp, pos_t rp);
      longint      l;
      longint      r;
      longint      t;
      longint      s;
      longint      err;
      longint      sp;
      longint      set_pt;
      longint      level;
      drive_word_t w;
      l = lp;
      r = rp;
      t = target;
      s = slant;
      if (mode) begin
        err            = t - l;
        sp             = pd_speed(err, prev_drive_err, gain_p, gain_d);
        prev_drive_err = err;
        left_speed     = slew(left_speed, sp - s);
        right_speed    = slew(right_speed, sp + s);
        drive_ticks++;
      end else begin
        set_pt        = (t > 0) ? (t * 235) / 100 : (t * 23) / 10;
        err           = set_pt - (r - l) / 2;
        sp            = pd_speed(err, prev_turn_err, TURN_KP, TURN_KD);
        prev_turn_err = err;
        left_speed    = slew(left_speed, -sp);
        right_speed   = slew(right_speed, sp);
        turn_ticks++;
      end
      level = (mag(l) + mag(r)) / 2;
      if (mag(last_level - level) < STALL_THRESH) begin
        if (still_count < STILL_MAX) still_count++;
      end else begin
        still_count = 0;
      end
      if (t != last_target) still_count = 0;
      last_target = t;
      last_level  = level;
      w.left   = drive_t'(left_speed);
      w.right  = drive_t'(right_speed);
      w.moving = !(still_count > STALL_LIMIT);
      if (!w.moving) stalled_words++;
      pending_words.push_back(w);
    endfunction

    function void check_word(drive_t l, drive_t r, logic mv);
      drive_word_t w;
      words_checked++;
      if (pending_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("word %0d arrived with nothing pending: left %0d right %0d moving %0b",
                   words_checked, l, r, mv);
        return;
      end
      w = pending_words.pop_front();
      if (l !== w.left || r !== w.right || mv !== w.moving) begin
        mismatches++;
        if (mismatches <= 10)
          $display("word %0d: left exp %0d got %0d, right exp %0d got %0d, moving exp %0b got %0b",
                   words_checked, w.left, l, w.right, r, w.moving, mv);
      end
    endfunction

    function int pending();
      return pending_words.size();
    endfunction
  endclass

  logic                 clk_i            = 1'b0;
  logic                 rst_ni           = 1'b0;
  logic                 in_valid_i       = 1'b0;
  logic                 in_ready_o;
  pos_t                 left_position_i  = '0;
  pos_t                 right_position_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i      = 1'b0;
  drive_t               left_drive_o;
  drive_t               right_drive_o;
  logic                 still_moving_o;
  logic                 cfg_we_i         = 1'b0;
  logic [IDX_W-1:0]     cfg_idx_i        = '0;
  logic [CFG_W-1:0]     cfg_wdata_i      = '0;

  int                   send_idle_pct  = 0;
  int                   recv_stall_pct = 0;
  int                   hold_cycles    = 0;
  int                   cycle_count    = 0;
  longint               walk_l         = 0;
  longint               walk_r         = 0;
  drive_command_tracker tracker        = new();

  pd_drive_controller_with_slew uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .left_position_i  (left_position_i),
    .right_position_i (right_position_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .left_drive_o     (left_drive_o),
    .right_drive_o    (right_drive_o),
    .still_moving_o   (still_moving_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i)
  );

  always #2 clk_i = ~clk_i;

  // Bound the run; a hung handshake ends here.
  always @(posedge clk_i) begin
    cycle_count = cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still pending",
               cycle_count, tracker.pending());
      $display("pd_drive_controller_with_slew: mismatch");
      $finish;
    end
  end

  // Receiver: honor a requested hold-off first, otherwise stall at random.
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      out_ready_i = 1'b0;
      hold_cycles = hold_cycles - 1;
    end else begin
      out_ready_i = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Check every word the block hands over.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      tracker.check_word(left_drive_o, right_drive_o, still_moving_o);
    end
  end

  function automatic longint rand_signed(longint span);
    return longint'($urandom_range(int'(2 * span))) - span;
  endfunction

  function automatic longint clamp_pos(longint v);
    if (v > longint'(POS_MAX)) return POS_MAX;
    if (v < longint'(POS_MIN)) return POS_MIN;
    return v;
  endfunction

  // Offer one position word after a random gap; return once it is taken.
  task automatic send_word(pos_t lp, pos_t rp);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i       = 1'b1;
    left_position_i  = lp;
    right_position_i = rp;
    do begin
      @(posedge clk_i);
    end while (!in_ready_o);
    tracker.note_positions(lp, rp);
  endtask

  // Drop valid and wait out every pending word plus the block's latency.
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, longint val);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = CFG_W'(val);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    tracker.set_reg(idx, CFG_W'(val));
  endtask

  task automatic write_all(longint md, longint tgt, longint maxs, longint sl,
                           longint gp, longint gd, longint acc, longint dec);
    write_reg(REG_MODE, md);
    write_reg(REG_TARGET, tgt);
    write_reg(REG_MAX_SPEED, maxs);
    write_reg(REG_SLANT, sl);
    write_reg(REG_GAIN_P, gp);
    write_reg(REG_GAIN_D, gd);
    write_reg(REG_ACCEL_SIZE, acc);
    write_reg(REG_DECEL_SIZE, dec);
  endtask

  // Edge cases: field extremes, the stall flag, a target change clearing
  // it, turn mode at both target extremes, and slew steps of zero.
  task automatic run_directed();
    send_word('0, '0);
    send_word(POS_MAX, POS_MAX);
    send_word(POS_MIN, POS_MIN);
    send_word(POS_MAX, POS_MIN);
    send_word(POS_MIN, POS_MAX);
    // Hold still long enough to raise the stall flag.
    repeat (6) send_word(100, -101);
    send_word(101, -100);
    drain_results();
    write_reg(REG_TARGET, 1000);
    send_word(100, -101);
    send_word(1000, 1000);
    drain_results();
    write_reg(REG_MODE, 0);
    write_reg(REG_TARGET, -1048576);
    send_word('0, '0);
    send_word(POS_MAX, POS_MIN);
    drain_results();
    write_reg(REG_TARGET, 1048575);
    send_word(POS_MIN, POS_MAX);
    send_word(-5000, 5000);
    drain_results();
    // Zero steps freeze both speeds.
    write_reg(REG_ACCEL_SIZE, 0);
    write_reg(REG_DECEL_SIZE, 0);
    send_word('0, '0);
    send_word(300, -300);
  endtask

  task automatic setup_phase(int p);
    longint tgt;
    tgt = ($urandom_range(3) == 0) ? rand_signed(1048575) : rand_signed(20000);
    case (p)
      0: write_all(1, tgt, 511, 255, 4095, 0, 1, 1023);
      1: write_all(0, -1048576, 511, -255, 0, 4095, 1023, 1);
      2: write_all(0, 1048575, 0, rand_signed(255), $urandom_range(4095),
                   $urandom_range(4095), $urandom_range(1023, 1), $urandom_range(1023, 1));
      3: write_all(1, -1048576, $urandom_range(511), rand_signed(255), $urandom_range(300),
                   $urandom_range(300), $urandom_range(1023, 1), $urandom_range(1023, 1));
      default: write_all($urandom_range(1), tgt, $urandom_range(511), rand_signed(255),
                         $urandom_range(1) ? $urandom_range(300) : $urandom_range(4095),
                         $urandom_range(1) ? $urandom_range(300) : $urandom_range(4095),
                         $urandom_range(1023, 1), $urandom_range(1023, 1));
    endcase
  endtask

  // Mostly track the set point with jitter of mixed size, often sit still so
  // the stall counter saturates, now and then jump to noise or the rails.
  task automatic pick_positions(output pos_t lp, output pos_t rp);
    int unsigned sel;
    longint      span;
    longint      t;
    pos_t        rnd;
    sel = $urandom_range(99);
    t   = tracker.target;
    case ($urandom_range(2))
      0: span = 8;
      1: span = 64;
      default: span = 700;
    endcase
    if (sel < 6) begin
      rnd    = pos_t'($urandom);
      walk_l = rnd;
      rnd    = pos_t'($urandom);
      walk_r = rnd;
    end else if (sel < 10) begin
      walk_l = $urandom_range(1) ? POS_MAX : POS_MIN;
      walk_r = $urandom_range(1) ? POS_MAX : POS_MIN;
    end else if (sel < 35) begin
      walk_l = walk_l + rand_signed(1);
      walk_r = walk_r + rand_signed(1);
    end else if (tracker.mode) begin
      walk_l = walk_l + (t - walk_l) / 4 + rand_signed(span);
      walk_r = walk_l + rand_signed(span);
    end else begin
      walk_l = walk_l + rand_signed(span);
      walk_r = walk_l + 2 * t + t / 3 + rand_signed(span);
    end
    walk_l = clamp_pos(walk_l);
    walk_r = clamp_pos(walk_r);
    lp = pos_t'(walk_l);
    rp = pos_t'(walk_r);
  endtask

  initial begin
    int   fails;
    pos_t lp;
    pos_t rp;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    run_directed();
    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      setup_phase(p);
      // Cycle through: no idling, sender idle, receiver stalling, both.
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
        default: begin send_idle_pct = 33; recv_stall_pct = 33; end
      endcase
      walk_l = tracker.target;
      walk_r = walk_l;
      for (int i = 0; i < WORDS_PER_PHASE; i++) begin
        pick_positions(lp, rp);
        send_word(lp, rp);
        // Back up the output while words keep coming, so the input stalls.
        if (i == 60 && p % 4 == 0) hold_cycles = HOLD_OFF_CYCLES;
        // Pause the sender until everything has come back.
        if (i == 120 && p == 5) drain_results();
      end
    end
    drain_results();
    repeat (20) @(posedge clk_i);
    fails = tracker.mismatches + tracker.pending();
    $display("checked %0d words: %0d drive ticks, %0d turn ticks, %0d with the stall flag",
             tracker.words_checked, tracker.drive_ticks, tracker.turn_ticks,
             tracker.stalled_words);
    $display("covered %0d register settings plus edge cases in %0d cycles, %0d failures",
             PHASES, cycle_count, fails);
    if (fails == 0) begin
      $display("pd_drive_controller_with_slew: match");
    end else begin
      $display("pd_drive_controller_with_slew: mismatch");
    end
    $finish;
  end

endmodule
